### src/qfactor_baseline_calibrator_defines.svh
// ----------------------------------------------------------------------------
// Q-factor baseline calibrator: assertion macros
// Shared concurrent assertion forms, clocked on clock and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef QFACTOR_BASELINE_CALIBRATOR_DEFINES_SVH
`define QFACTOR_BASELINE_CALIBRATOR_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define QBC_ASSERT_SAME(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("qbc assertion failed (same cycle)");

// The consequent must hold in the cycle after the antecedent.
`define QBC_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("qbc assertion failed (next cycle)");

`endif

### src/qbc_pkg.sv
// ----------------------------------------------------------------------------
// Q-factor baseline calibrator package
// Field widths, status and register codes, and the shared struct types.
// ----------------------------------------------------------------------------
`default_nettype none

package qbc_pkg;

   // Width of every measurement and configuration value.
   localparam int unsigned VAL_W = 12;

   // Width of the sample counter, enough for the default run length and average size.
   localparam int unsigned CNT_W = 4;

   // Slack added to the Q lower-bound test.
   localparam logic [VAL_W-1:0] Q_SLACK = 12'd20;

   // Status codes reported with each result.
   localparam logic [1:0] STATUS_WAIT = 2'd0;
   localparam logic [1:0] STATUS_AVG  = 2'd1;
   localparam logic [1:0] STATUS_DONE = 2'd2;

   // Configuration register indexes.
   localparam int unsigned CSR_IDX_W = 3;
   localparam logic [CSR_IDX_W-1:0] CSR_Q_BASE      = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_Q_MARGIN    = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_Q_UPPER     = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_FREQ_BASE   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_FREQ_MARGIN = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_FREQ_UPPER  = 3'd5;

   // Calibration phase, one-hot.
   typedef enum logic [2:0] {
      PHASE_WAIT = 3'b001,
      PHASE_AVG  = 3'b010,
      PHASE_DONE = 3'b100
   } phase_type;

   // Window configuration.
   typedef struct packed {
      logic [VAL_W-1:0] q_base;
      logic [VAL_W-1:0] q_margin;
      logic [VAL_W-1:0] q_upper;
      logic [VAL_W-1:0] freq_base;
      logic [VAL_W-1:0] freq_margin;
      logic [VAL_W-1:0] freq_upper;
   } cfg_type;

   // One result item.
   typedef struct packed {
      logic [1:0]       status;
      logic [VAL_W-1:0] q_average;
      logic [VAL_W-1:0] freq_average;
      logic             done_pulse;
   } rsp_type;

endpackage

`default_nettype wire

### src/qbc_calc.sv
// ----------------------------------------------------------------------------
// Q-factor baseline calibrator: calibration engine
// Holds the phase, run counter and accumulators, and forms one result per
// transfer from the window test and the running sums.
// ----------------------------------------------------------------------------
`default_nettype none

module qbc_calc #(
   parameter int unsigned QUALIFY_COUNT = 10,
   parameter int unsigned AVERAGE_LOG2  = 3
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          item_accept,
   input  wire logic                          mode,
   input  wire logic [qbc_pkg::VAL_W-1:0]     q_meas,
   input  wire logic [qbc_pkg::VAL_W-1:0]     freq_meas,
   input  wire qbc_pkg::cfg_type              cfg,
   output qbc_pkg::rsp_type                   result
);
   import qbc_pkg::*;

   localparam int unsigned ACC_W = VAL_W + AVERAGE_LOG2;
   localparam logic [CNT_W-1:0] QUAL_LIMIT = CNT_W'(QUALIFY_COUNT);
   localparam logic [CNT_W-1:0] AVG_LIMIT  = CNT_W'(1 << AVERAGE_LOG2);

   phase_type         phase_ff, phase_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [ACC_W-1:0]  q_acc_ff, q_acc_in;
   logic [ACC_W-1:0]  f_acc_ff, f_acc_in;

   logic              in_window;
   logic [CNT_W-1:0]  count_inc;
   logic [ACC_W-1:0]  q_sum;
   logic [ACC_W-1:0]  f_sum;
   logic [VAL_W-1:0]  q_shift;
   logic [VAL_W-1:0]  f_shift;
   logic              pulse;

   // Clear-coil window: sums are widened so they never wrap.
   assign in_window =
      ((14'(q_meas) + 14'(cfg.q_margin) + 14'(Q_SLACK)) > 14'(cfg.q_base)) &&
      (q_meas < cfg.q_upper) &&
      ((13'(freq_meas) + 13'(cfg.freq_margin)) > 13'(cfg.freq_base)) &&
      (freq_meas < cfg.freq_upper);

   assign count_inc = count_ff + CNT_W'(1);
   assign q_sum     = q_acc_ff + ACC_W'(q_meas);
   assign f_sum     = f_acc_ff + ACC_W'(freq_meas);
   assign q_shift   = VAL_W'(q_sum >> AVERAGE_LOG2);
   assign f_shift   = VAL_W'(f_sum >> AVERAGE_LOG2);

   // Next phase, counter and accumulators for the item on the inputs.
   always_comb begin
      phase_in = phase_ff;
      count_in = count_ff;
      q_acc_in = q_acc_ff;
      f_acc_in = f_acc_ff;
      pulse    = 1'b0;
      if (mode) begin
         phase_in = PHASE_WAIT;
         count_in = '0;
         q_acc_in = '0;
         f_acc_in = '0;
      end else begin
         unique case (phase_ff)
            PHASE_AVG: begin
               q_acc_in = q_sum;
               f_acc_in = f_sum;
               count_in = count_inc;
               if (count_inc >= AVG_LIMIT) begin
                  q_acc_in = ACC_W'(q_shift);
                  f_acc_in = ACC_W'(f_shift);
                  count_in = '0;
                  phase_in = PHASE_DONE;
                  pulse    = 1'b1;
               end
            end
            PHASE_DONE: begin
               // Hold the averages until a restart.
            end
            default: begin
               phase_in = PHASE_WAIT;
               if (in_window) begin
                  count_in = count_inc;
                  if (count_inc >= QUAL_LIMIT) begin
                     count_in = '0;
                     q_acc_in = '0;
                     f_acc_in = '0;
                     phase_in = PHASE_AVG;
                  end
               end else begin
                  count_in = '0;
               end
            end
         endcase
      end
   end

   // Result for the item on the inputs, reported as the phase after it.
   always_comb begin
      result.done_pulse   = pulse;
      result.q_average    = '0;
      result.freq_average = '0;
      unique case (phase_in)
         PHASE_AVG: begin
            result.status = STATUS_AVG;
         end
         PHASE_DONE: begin
            result.status       = STATUS_DONE;
            result.q_average    = q_acc_in[VAL_W-1:0];
            result.freq_average = f_acc_in[VAL_W-1:0];
         end
         default: begin
            result.status = STATUS_WAIT;
         end
      endcase
   end

   // Calibration state advances on every transfer.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PHASE_WAIT;
         count_ff <= '0;
         q_acc_ff <= '0;
         f_acc_ff <= '0;
      end else if (item_accept) begin
         phase_ff <= phase_in;
         count_ff <= count_in;
         q_acc_ff <= q_acc_in;
         f_acc_ff <= f_acc_in;
      end
   end

endmodule

`default_nettype wire

### src/qbc_skid.sv
// ----------------------------------------------------------------------------
// Q-factor baseline calibrator: result buffer
// Two-entry output buffer so that a new item is taken while a result waits
// and the request ready does not depend combinationally on the response side.
// ----------------------------------------------------------------------------
`default_nettype none

module qbc_skid (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             in_valid,
   output logic                  in_ready,
   input  wire qbc_pkg::rsp_type in_data,
   output logic                  out_valid,
   input  wire logic             out_ready,
   output qbc_pkg::rsp_type      out_data
);
   import qbc_pkg::*;

   logic    main_valid_ff;
   logic    skid_valid_ff;
   rsp_type main_ff;
   rsp_type skid_ff;
   logic    take;

   assign take      = main_valid_ff && out_ready;
   assign in_ready  = !skid_valid_ff;
   assign out_valid = main_valid_ff;
   assign out_data  = main_ff;

   // Occupancy: the skid entry fills only when the main entry is held.
   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (in_valid) begin
         if (main_valid_ff && !take) begin
            skid_valid_ff <= 1'b1;
         end else begin
            main_valid_ff <= 1'b1;
         end
      end else if (take) begin
         if (skid_valid_ff) begin
            skid_valid_ff <= 1'b0;
         end else begin
            main_valid_ff <= 1'b0;
         end
      end
   end

   // Payload entries.
   always_ff @(posedge clock) begin
      if (in_valid) begin
         if (main_valid_ff && !take) begin
            skid_ff <= in_data;
         end else begin
            main_ff <= in_data;
         end
      end else if (take && skid_valid_ff) begin
         main_ff <= skid_ff;
      end
   end

endmodule

`default_nettype wire

### src/qfactor_baseline_calibrator.sv
// ----------------------------------------------------------------------------
// Q-factor baseline calibrator
// Qualifies a clear coil from Q and frequency samples, then averages a block
// of samples to give new baselines.
// ----------------------------------------------------------------------------
// The block takes one request per clock cycle and gives one response for each,
// in order. The result of a transfer is computed in the cycle of the transfer
// and is registered in a two-entry output buffer before the response port;
// while the buffer is full the request ready is low. Sustained rate is one
// item per cycle whenever responses are taken. The user must write registers
// through the csr port only while no response is pending; nothing enforces it.
`default_nettype none

`include "qfactor_baseline_calibrator_defines.svh"

module qfactor_baseline_calibrator #(
   parameter int unsigned QUALIFY_COUNT = 10,
   parameter int unsigned AVERAGE_LOG2  = 3
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_valid,
   output logic                                   req_ready,
   input  wire logic                              req_mode,
   input  wire logic [qbc_pkg::VAL_W-1:0]         req_q_meas,
   input  wire logic [qbc_pkg::VAL_W-1:0]         req_freq_meas,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_ready,
   output logic [1:0]                             rsp_status,
   output logic [qbc_pkg::VAL_W-1:0]              rsp_q_average,
   output logic [qbc_pkg::VAL_W-1:0]              rsp_freq_average,
   output logic                                   rsp_done_pulse,
   input  wire logic                              csr_write_enable,
   input  wire logic [qbc_pkg::CSR_IDX_W-1:0]     csr_index,
   input  wire logic [qbc_pkg::VAL_W-1:0]         csr_write_data
);
   import qbc_pkg::*;

   cfg_type cfg_ff;
   rsp_type calc_result;
   rsp_type out_result;
   logic    item_accept;

   assign item_accept = req_valid && req_ready;

   // Configuration registers; unknown indexes are ignored.
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.q_base      <= '0;
         cfg_ff.q_margin    <= '0;
         cfg_ff.q_upper     <= '1;
         cfg_ff.freq_base   <= '0;
         cfg_ff.freq_margin <= '0;
         cfg_ff.freq_upper  <= '1;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CSR_Q_BASE:      cfg_ff.q_base      <= csr_write_data;
            CSR_Q_MARGIN:    cfg_ff.q_margin    <= csr_write_data;
            CSR_Q_UPPER:     cfg_ff.q_upper     <= csr_write_data;
            CSR_FREQ_BASE:   cfg_ff.freq_base   <= csr_write_data;
            CSR_FREQ_MARGIN: cfg_ff.freq_margin <= csr_write_data;
            CSR_FREQ_UPPER:  cfg_ff.freq_upper  <= csr_write_data;
            default: begin
            end
         endcase
      end
   end

   // Calibration engine.
   qbc_calc #(
      .QUALIFY_COUNT (QUALIFY_COUNT),
      .AVERAGE_LOG2  (AVERAGE_LOG2)
   ) u_calc (
      .clock       (clock),
      .reset       (reset),
      .item_accept (item_accept),
      .mode        (req_mode),
      .q_meas      (req_q_meas),
      .freq_meas   (req_freq_meas),
      .cfg         (cfg_ff),
      .result      (calc_result)
   );

   // Output buffer.
   qbc_skid u_skid (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (item_accept),
      .in_ready  (req_ready),
      .in_data   (calc_result),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .out_data  (out_result)
   );

   assign rsp_status       = out_result.status;
   assign rsp_q_average    = out_result.q_average;
   assign rsp_freq_average = out_result.freq_average;
   assign rsp_done_pulse   = out_result.done_pulse;

   // A completion pulse always comes with the done status.
   `QBC_ASSERT_SAME(a_pulse_done, rsp_valid && rsp_done_pulse, rsp_status == STATUS_DONE)

   // Averages are zero unless calibration is done.
   `QBC_ASSERT_SAME(a_avg_zero, rsp_valid && (rsp_status != STATUS_DONE),
                    (rsp_q_average == '0) && (rsp_freq_average == '0))

   // Every transfer leaves a response pending in the next cycle.
   `QBC_ASSERT_NEXT(a_rsp_follows, req_valid && req_ready, rsp_valid)

   // The buffer never refuses a request while it holds no response.
   `QBC_ASSERT_SAME(a_ready_empty, !rsp_valid, req_ready)

endmodule

`default_nettype wire
